FILE: hdl/timed_actuator_sequencer_defines.svh
// assertion macros for the actuator sequencer checker
`ifndef TIMED_ACTUATOR_SEQUENCER_DEFINES_SVH
`define TIMED_ACTUATOR_SEQUENCER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define TAS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hdl/tas_pkg.sv
// types, codes and constants for the actuator sequencer
package tas_pkg;
    localparam int TIMER_BITS_DEF = 17;
    localparam logic [15:0] ARM_DUR_RST = 16'd4000;
    localparam logic [15:0] LID_DUR_RST = 16'd4700;
    localparam logic [15:0] LID_EXTRA_RST = 16'd600;
    localparam logic [7:0] ARM_FWD_RST = 8'd50;
    localparam logic [7:0] ARM_BWD_RST = 8'd128;
    localparam logic [7:0] LID_DUTY_RST = 8'd20;
    localparam logic [7:0] RD_UNKNOWN = 8'hFF;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [7:0] ADDR_PAN_HI = 8'h00;
    localparam logic [7:0] ADDR_PAN_LO = 8'h01;
    localparam logic [7:0] ADDR_ARM_ST = 8'h02;
    localparam logic [7:0] ADDR_BUSY = 8'h03;
    localparam logic [7:0] ADDR_LID_ST = 8'h04;
    localparam logic [7:0] ADDR_PAN_CMD = 8'h10;
    localparam logic [7:0] ADDR_PAN_TGT = 8'h11;
    localparam logic [7:0] ADDR_ARM_CMD = 8'h13;
    localparam logic [7:0] ADDR_LID_CMD = 8'h16;

    localparam logic [1:0] POS_HOME = 2'd0;
    localparam logic [1:0] POS_PLATE = 2'd1;
    localparam logic [1:0] POS_MOVE = 2'd2;

    localparam logic [1:0] DRV_COAST = 2'd0;
    localparam logic [1:0] DRV_FWD = 2'd1;
    localparam logic [1:0] DRV_BWD = 2'd2;

    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_T_PLATE = 3'd1;
    localparam logic [2:0] CMD_T_HOME = 3'd2;
    localparam logic [2:0] CMD_C_PLATE = 3'd3;
    localparam logic [2:0] CMD_C_HOME = 3'd4;
    localparam logic [2:0] CMD_STOP = 3'd5;

    localparam logic [7:0] BYTE_PAN_STOP = 8'd1;
    localparam logic [7:0] BYTE_PAN_HOME = 8'd2;
    localparam logic [7:0] BYTE_SEQ_OPEN = 8'd6;
    localparam logic [7:0] BYTE_SEQ_CLOSE = 8'd7;

    localparam logic [1:0] SEQ_OFF = 2'd0;
    localparam logic [1:0] SEQ_PH1 = 2'd1;
    localparam logic [1:0] SEQ_PH2 = 2'd2;
    localparam logic [1:0] SGOAL_NONE = 2'd0;
    localparam logic [1:0] SGOAL_OPEN = 2'd1;
    localparam logic [1:0] SGOAL_CLOSE = 2'd2;

    localparam logic [2:0] CFG_ARM_DUR = 3'd0;
    localparam logic [2:0] CFG_LID_DUR = 3'd1;
    localparam logic [2:0] CFG_LID_EXTRA = 3'd2;
    localparam logic [2:0] CFG_ARM_FWD = 3'd3;
    localparam logic [2:0] CFG_ARM_BWD = 3'd4;
    localparam logic [2:0] CFG_LID_DUTY = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  reg_addr;
        logic [15:0] write_data;
        logic [1:0]  write_bytes;
        logic        limit_switch;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] arm_drive;
        logic [7:0] arm_duty;
        logic [1:0] lid_drive;
        logic [7:0] lid_duty_res;
        logic [2:0] busy_bits;
    } out_word_t;

    // classified operation handed from front to back
    typedef struct packed {
        logic        is_tick;
        logic        is_read;
        logic        limit;
        logic [7:0]  rd_addr;
        logic        pan_stop;
        logic        pan_home;
        logic        pan_tgt;
        logic [15:0] pan_val;
        logic        seq_req;
        logic [1:0]  seq_goal;
        logic        arm_cmd_wr;
        logic [2:0]  arm_cmd;
        logic        lid_cmd_wr;
        logic [2:0]  lid_cmd;
    } op_t;

    typedef struct packed {
        logic [15:0] arm_dur;
        logic [15:0] lid_dur;
        logic [15:0] lid_extra;
        logic [7:0]  arm_fwd;
        logic [7:0]  arm_bwd;
        logic [7:0]  lid_duty;
    } cfg_t;

    function automatic logic [2:0] cmd_code(input logic [7:0] b);
        logic [2:0] r;
        r = CMD_NONE;
        if (b >= 8'd1 && b <= 8'd5) r = b[2:0];
        return r;
    endfunction
endpackage

FILE: hdl/timed_actuator_sequencer.sv
// top level of the timed actuator sequencer
//
//  channel   direction  handshake        word
//  in        in         in_valid/stall   tas_pkg::in_word_t
//  out       out        out_valid/stall  tas_pkg::out_word_t
//  cfg       in         valid/ready      index 3b, data 16b
//
// one word per cycle sustained while the output is not stalled: the front
// decodes combinationally into a two-entry queue, the back applies one
// operation a cycle from the stage register and registers the result
// async active-low reset of all but queue storage, stage_op and out_reg
// a stalled output holds the back; the queue then fills and stalls the input
module timed_actuator_sequencer #(
    parameter int TIMER_BITS = tas_pkg::TIMER_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tas_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output tas_pkg::out_word_t out_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    tas_pkg::cfg_t cfg_reg;
    tas_pkg::op_t  dec_op, q_op, stage_op;
    logic          stage_valid_reg;
    logic          q_full, q_valid, q_take, back_take;

    // configuration registers, always writable
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arm_dur   <= tas_pkg::ARM_DUR_RST;
            cfg_reg.lid_dur   <= tas_pkg::LID_DUR_RST;
            cfg_reg.lid_extra <= tas_pkg::LID_EXTRA_RST;
            cfg_reg.arm_fwd   <= tas_pkg::ARM_FWD_RST;
            cfg_reg.arm_bwd   <= tas_pkg::ARM_BWD_RST;
            cfg_reg.lid_duty  <= tas_pkg::LID_DUTY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tas_pkg::CFG_ARM_DUR:   cfg_reg.arm_dur <= cfg_data;
                tas_pkg::CFG_LID_DUR:   cfg_reg.lid_dur <= cfg_data;
                tas_pkg::CFG_LID_EXTRA: cfg_reg.lid_extra <= cfg_data;
                tas_pkg::CFG_ARM_FWD:   cfg_reg.arm_fwd <= cfg_data[7:0];
                tas_pkg::CFG_ARM_BWD:   cfg_reg.arm_bwd <= cfg_data[7:0];
                tas_pkg::CFG_LID_DUTY:  cfg_reg.lid_duty <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // front: decode combinationally, queue holds classified words
    tas_front u_front (
        .in_word (in_word),
        .op      (dec_op)
    );

    assign in_stall = q_full;

    tas_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_valid && !q_full),
        .wr_op    (dec_op),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_take),
        .rd_op    (q_op)
    );

    // single stage register between queue and back
    assign q_take = q_valid && (!stage_valid_reg || back_take);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (q_take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (back_take)
        begin
            stage_valid_reg <= 1'b0;
        end
    end
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            stage_op <= q_op;
        end
    end

    // back: state update and result register
    tas_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (stage_valid_reg),
        .op        (stage_op),
        .op_take   (back_take),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );
endmodule

FILE: hdl/tas_front.sv
// decodes input words into classified operations
module tas_front (
    input  tas_pkg::in_word_t in_word,
    output tas_pkg::op_t      op
);
    logic [7:0] b0;
    logic       wr;

    always_comb
    begin
        b0 = in_word.write_data[15:8];
        wr = (in_word.action == tas_pkg::ACT_WRITE) && (in_word.write_bytes != 2'd0);
        op = '0;
        op.is_tick = in_word.action == tas_pkg::ACT_TICK;
        op.is_read = in_word.action == tas_pkg::ACT_READ;
        op.limit = in_word.limit_switch;
        op.rd_addr = in_word.reg_addr;
        op.pan_val = in_word.write_data;
        if (wr)
        begin
            case (in_word.reg_addr)
                tas_pkg::ADDR_PAN_CMD:
                begin
                    op.pan_stop = b0 == tas_pkg::BYTE_PAN_STOP;
                    op.pan_home = b0 == tas_pkg::BYTE_PAN_HOME;
                end
                tas_pkg::ADDR_PAN_TGT: op.pan_tgt = in_word.write_bytes >= 2'd2;
                tas_pkg::ADDR_ARM_CMD:
                begin
                    if (b0 == tas_pkg::BYTE_SEQ_OPEN || b0 == tas_pkg::BYTE_SEQ_CLOSE)
                    begin
                        op.seq_req = 1'b1;
                        op.seq_goal = (b0 == tas_pkg::BYTE_SEQ_OPEN) ?
                            tas_pkg::SGOAL_OPEN : tas_pkg::SGOAL_CLOSE;
                    end
                    else
                    begin
                        op.arm_cmd_wr = 1'b1;
                        op.arm_cmd = tas_pkg::cmd_code(b0);
                    end
                end
                tas_pkg::ADDR_LID_CMD:
                begin
                    op.lid_cmd_wr = 1'b1;
                    op.lid_cmd = tas_pkg::cmd_code(b0);
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: hdl/tas_queue.sv
// two-entry queue between front and back
module tas_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  tas_pkg::op_t  wr_op,
    output logic          full,
    output logic          rd_valid,
    input  logic          rd_en,
    output tas_pkg::op_t  rd_op
);
    tas_pkg::op_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_op = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end
endmodule

FILE: hdl/tas_back.sv
// executes operations against the actuator state and registers the result word
module tas_back #(
    parameter int TIMER_BITS = tas_pkg::TIMER_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  tas_pkg::op_t       op,
    output logic               op_take,
    input  tas_pkg::cfg_t      cfg,
    output logic               out_valid,
    input  logic               out_stall,
    output tas_pkg::out_word_t out_word
);
    localparam logic [TIMER_BITS-1:0] TMAX = '1;
    // compare width covers both the timer and the 17-bit open duration
    localparam int CW = (TIMER_BITS > 17) ? TIMER_BITS : 17;

    logic [15:0] pan_pos_reg, pan_pos_next, pan_goal_reg, pan_goal_next;
    logic pan_stop_reg, pan_stop_next, pan_home_reg, pan_home_next;
    logic [1:0] arm_pos_reg, arm_pos_next, arm_goal_reg, arm_goal_next;
    logic [2:0] arm_req_reg, arm_req_next;
    logic [TIMER_BITS-1:0] arm_el_reg, arm_el_next;
    logic arm_tm_reg, arm_tm_next;
    logic [1:0] lid_pos_reg, lid_pos_next, lid_goal_reg, lid_goal_next;
    logic [2:0] lid_req_reg, lid_req_next;
    logic [TIMER_BITS-1:0] lid_el_reg, lid_el_next;
    logic lid_tm_reg, lid_tm_next;
    logic [1:0] seq_ph_reg, seq_ph_next, seq_goal_reg, seq_goal_next;
    logic limit_reg, limit_next;
    logic [2:0] busy_reg, busy_next;
    logic [7:0] rd;
    logic skip_seq;
    logic [CW-1:0] arm_dur, lid_dur, open_dur, lid_tgt;
    logic out_valid_reg;
    tas_pkg::out_word_t out_reg;

    assign op_take = op_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_word = out_reg;

    always_comb
    begin
        arm_dur = CW'(cfg.arm_dur);
        lid_dur = CW'(cfg.lid_dur);
        open_dur = CW'({1'b0, cfg.lid_dur} + {1'b0, cfg.lid_extra});
        pan_pos_next = pan_pos_reg; pan_goal_next = pan_goal_reg;
        pan_stop_next = pan_stop_reg; pan_home_next = pan_home_reg;
        arm_pos_next = arm_pos_reg; arm_goal_next = arm_goal_reg;
        arm_req_next = arm_req_reg; arm_el_next = arm_el_reg;
        arm_tm_next = arm_tm_reg;
        lid_pos_next = lid_pos_reg; lid_goal_next = lid_goal_reg;
        lid_req_next = lid_req_reg; lid_el_next = lid_el_reg;
        lid_tm_next = lid_tm_reg;
        seq_ph_next = seq_ph_reg; seq_goal_next = seq_goal_reg;
        limit_next = limit_reg; busy_next = busy_reg;
        rd = 8'd0;
        skip_seq = 1'b0;
        lid_tgt = '0;

        if (op.is_read)
        begin
            case (op.rd_addr)
                tas_pkg::ADDR_PAN_HI: rd = pan_pos_reg[15:8];
                tas_pkg::ADDR_PAN_LO: rd = pan_pos_reg[7:0];
                tas_pkg::ADDR_ARM_ST: rd = {6'd0, arm_pos_reg};
                tas_pkg::ADDR_BUSY:   rd = {5'd0, busy_reg};
                tas_pkg::ADDR_LID_ST: rd = {6'd0, lid_pos_reg};
                default:              rd = tas_pkg::RD_UNKNOWN;
            endcase
        end

        if (op.pan_stop) pan_stop_next = 1'b1;
        if (op.pan_home) pan_home_next = 1'b1;
        if (op.pan_tgt) pan_goal_next = op.pan_val;
        if (op.seq_req)
        begin
            seq_goal_next = op.seq_goal;
            seq_ph_next = tas_pkg::SEQ_PH1;
        end
        if (op.arm_cmd_wr) arm_req_next = op.arm_cmd;
        if (op.lid_cmd_wr) lid_req_next = op.lid_cmd;

        if (op.is_tick)
        begin
            if (arm_el_next != TMAX) arm_el_next = arm_el_next + TIMER_BITS'(1);
            if (lid_el_next != TMAX) lid_el_next = lid_el_next + TIMER_BITS'(1);
            if (op.limit) limit_next = 1'b1;
            // arm command
            case (arm_req_reg)
                tas_pkg::CMD_T_PLATE, tas_pkg::CMD_T_HOME, tas_pkg::CMD_C_PLATE,
                tas_pkg::CMD_C_HOME:
                begin
                    arm_goal_next = (arm_req_reg == tas_pkg::CMD_T_PLATE ||
                        arm_req_reg == tas_pkg::CMD_C_PLATE) ?
                        tas_pkg::POS_PLATE : tas_pkg::POS_HOME;
                    arm_pos_next = tas_pkg::POS_MOVE;
                    arm_tm_next = arm_req_reg == tas_pkg::CMD_T_PLATE ||
                        arm_req_reg == tas_pkg::CMD_T_HOME;
                    if (arm_tm_next) arm_el_next = '0;
                    busy_next[1] = 1'b1;
                end
                tas_pkg::CMD_STOP:
                begin
                    arm_pos_next = tas_pkg::POS_HOME;
                    arm_tm_next = 1'b0;
                    busy_next[1] = 1'b0;
                end
                default: ;
            endcase
            arm_req_next = tas_pkg::CMD_NONE;
            if (arm_pos_next == tas_pkg::POS_MOVE)
            begin
                if (op.limit)
                begin
                    arm_pos_next = tas_pkg::POS_HOME;
                    arm_tm_next = 1'b0;
                    busy_next[1] = 1'b0;
                    skip_seq = 1'b1;
                end
                else if (arm_tm_next && CW'(arm_el_next) >= arm_dur)
                begin
                    arm_pos_next = arm_goal_next;
                    busy_next[1] = 1'b0;
                end
            end
            // open/close sequencer
            if (!skip_seq)
            begin
                if (seq_ph_next == tas_pkg::SEQ_PH1 && seq_goal_next == tas_pkg::SGOAL_OPEN)
                begin
                    if (lid_pos_next == tas_pkg::POS_PLATE) seq_ph_next = tas_pkg::SEQ_PH2;
                    else if (lid_pos_next == tas_pkg::POS_HOME)
                    begin
                        lid_goal_next = tas_pkg::POS_PLATE; lid_pos_next = tas_pkg::POS_MOVE;
                        lid_tm_next = 1'b1; lid_el_next = '0; busy_next[2] = 1'b1;
                    end
                    else if (lid_pos_next == tas_pkg::POS_MOVE && CW'(lid_el_next) >= open_dur)
                    begin
                        lid_pos_next = tas_pkg::POS_PLATE; lid_tm_next = 1'b0;
                        busy_next[2] = 1'b0; seq_ph_next = tas_pkg::SEQ_PH2;
                    end
                end
                else if (seq_ph_next == tas_pkg::SEQ_PH1 &&
                         seq_goal_next == tas_pkg::SGOAL_CLOSE)
                begin
                    if (arm_pos_next == tas_pkg::POS_HOME) seq_ph_next = tas_pkg::SEQ_PH2;
                    else if (arm_pos_next == tas_pkg::POS_PLATE)
                    begin
                        arm_goal_next = tas_pkg::POS_HOME; arm_pos_next = tas_pkg::POS_MOVE;
                        arm_tm_next = 1'b1; arm_el_next = '0; busy_next[1] = 1'b1;
                    end
                    else if (arm_pos_next == tas_pkg::POS_MOVE && CW'(arm_el_next) >= arm_dur)
                    begin
                        arm_pos_next = tas_pkg::POS_HOME; arm_tm_next = 1'b0;
                        busy_next[1] = 1'b0; seq_ph_next = tas_pkg::SEQ_PH2;
                    end
                end
                else if (seq_ph_next == tas_pkg::SEQ_PH2 &&
                         seq_goal_next == tas_pkg::SGOAL_OPEN)
                begin
                    if (arm_pos_next == tas_pkg::POS_PLATE)
                    begin
                        seq_ph_next = tas_pkg::SEQ_OFF; seq_goal_next = tas_pkg::SGOAL_NONE;
                    end
                    else if (arm_pos_next == tas_pkg::POS_HOME)
                    begin
                        arm_goal_next = tas_pkg::POS_PLATE; arm_pos_next = tas_pkg::POS_MOVE;
                        arm_tm_next = 1'b1; arm_el_next = '0; busy_next[1] = 1'b1;
                    end
                    else if (arm_pos_next == tas_pkg::POS_MOVE && CW'(arm_el_next) >= arm_dur)
                    begin
                        arm_pos_next = tas_pkg::POS_PLATE; arm_tm_next = 1'b0;
                        busy_next[1] = 1'b0;
                        seq_ph_next = tas_pkg::SEQ_OFF; seq_goal_next = tas_pkg::SGOAL_NONE;
                    end
                end
                else if (seq_ph_next == tas_pkg::SEQ_PH2 &&
                         seq_goal_next == tas_pkg::SGOAL_CLOSE)
                begin
                    if (lid_pos_next == tas_pkg::POS_HOME)
                    begin
                        seq_ph_next = tas_pkg::SEQ_OFF; seq_goal_next = tas_pkg::SGOAL_NONE;
                    end
                    else if (lid_pos_next == tas_pkg::POS_PLATE)
                    begin
                        lid_goal_next = tas_pkg::POS_HOME; lid_pos_next = tas_pkg::POS_MOVE;
                        lid_tm_next = 1'b1; lid_el_next = '0; busy_next[2] = 1'b1;
                    end
                    else if (lid_pos_next == tas_pkg::POS_MOVE && CW'(lid_el_next) >= lid_dur)
                    begin
                        lid_pos_next = tas_pkg::POS_HOME; lid_tm_next = 1'b0;
                        busy_next[2] = 1'b0;
                        seq_ph_next = tas_pkg::SEQ_OFF; seq_goal_next = tas_pkg::SGOAL_NONE;
                    end
                end
            end
            // lid command
            case (lid_req_reg)
                tas_pkg::CMD_T_PLATE, tas_pkg::CMD_T_HOME, tas_pkg::CMD_C_PLATE,
                tas_pkg::CMD_C_HOME:
                begin
                    lid_goal_next = (lid_req_reg == tas_pkg::CMD_T_HOME ||
                        lid_req_reg == tas_pkg::CMD_C_PLATE) ?
                        tas_pkg::POS_PLATE : tas_pkg::POS_HOME;
                    lid_pos_next = tas_pkg::POS_MOVE;
                    lid_tm_next = lid_req_reg == tas_pkg::CMD_T_PLATE ||
                        lid_req_reg == tas_pkg::CMD_T_HOME;
                    if (lid_tm_next) lid_el_next = '0;
                    busy_next[2] = 1'b1;
                end
                tas_pkg::CMD_STOP:
                begin
                    lid_pos_next = tas_pkg::POS_HOME;
                    lid_tm_next = 1'b0;
                    busy_next[2] = 1'b0;
                end
                default: ;
            endcase
            lid_req_next = tas_pkg::CMD_NONE;
            if (lid_pos_next == tas_pkg::POS_MOVE)
            begin
                lid_tgt = (lid_goal_next == tas_pkg::POS_PLATE) ? open_dur : lid_dur;
                if (limit_next)
                begin
                    lid_pos_next = tas_pkg::POS_HOME;
                    lid_tm_next = 1'b0;
                    busy_next[2] = 1'b0;
                    limit_next = 1'b0;
                    seq_ph_next = tas_pkg::SEQ_OFF;
                end
                else if (lid_tm_next && CW'(lid_el_next) >= lid_tgt)
                begin
                    lid_pos_next = lid_goal_next;
                    busy_next[2] = 1'b0;
                end
            end
            // pan
            if (pan_stop_reg)
            begin
                pan_stop_next = 1'b0;
                pan_goal_next = pan_pos_reg;
            end
            if (pan_home_reg)
            begin
                pan_home_next = 1'b0;
                pan_goal_next = '0;
            end
            pan_pos_next = pan_goal_next;
            busy_next[0] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_pos_reg <= '0; pan_goal_reg <= '0;
            pan_stop_reg <= 1'b0; pan_home_reg <= 1'b0;
            arm_pos_reg <= tas_pkg::POS_HOME; arm_goal_reg <= tas_pkg::POS_HOME;
            arm_req_reg <= tas_pkg::CMD_NONE; arm_el_reg <= '0; arm_tm_reg <= 1'b0;
            lid_pos_reg <= tas_pkg::POS_HOME; lid_goal_reg <= tas_pkg::POS_HOME;
            lid_req_reg <= tas_pkg::CMD_NONE; lid_el_reg <= '0; lid_tm_reg <= 1'b0;
            seq_ph_reg <= tas_pkg::SEQ_OFF; seq_goal_reg <= tas_pkg::SGOAL_NONE;
            limit_reg <= 1'b0; busy_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_take)
            begin
                pan_pos_reg <= pan_pos_next; pan_goal_reg <= pan_goal_next;
                pan_stop_reg <= pan_stop_next; pan_home_reg <= pan_home_next;
                arm_pos_reg <= arm_pos_next; arm_goal_reg <= arm_goal_next;
                arm_req_reg <= arm_req_next; arm_el_reg <= arm_el_next;
                arm_tm_reg <= arm_tm_next;
                lid_pos_reg <= lid_pos_next; lid_goal_reg <= lid_goal_next;
                lid_req_reg <= lid_req_next; lid_el_reg <= lid_el_next;
                lid_tm_reg <= lid_tm_next;
                seq_ph_reg <= seq_ph_next; seq_goal_reg <= seq_goal_next;
                limit_reg <= limit_next; busy_reg <= busy_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            out_reg.read_data <= rd;
            out_reg.arm_drive <= (arm_pos_next != tas_pkg::POS_MOVE) ? tas_pkg::DRV_COAST :
                (arm_goal_next == tas_pkg::POS_PLATE) ? tas_pkg::DRV_FWD : tas_pkg::DRV_BWD;
            out_reg.arm_duty <= (arm_pos_next != tas_pkg::POS_MOVE) ? 8'd0 :
                (arm_goal_next == tas_pkg::POS_PLATE) ? cfg.arm_fwd : cfg.arm_bwd;
            out_reg.lid_drive <= (lid_pos_next != tas_pkg::POS_MOVE) ? tas_pkg::DRV_COAST :
                (lid_goal_next == tas_pkg::POS_PLATE) ? tas_pkg::DRV_FWD : tas_pkg::DRV_BWD;
            out_reg.lid_duty_res <= (lid_pos_next != tas_pkg::POS_MOVE) ? 8'd0 : cfg.lid_duty;
            out_reg.busy_bits <= busy_next;
        end
    end
endmodule

FILE: hdl/tas_checker.sv
// port-level checker for the actuator sequencer, bound to the top level
`include "timed_actuator_sequencer_defines.svh"
module tas_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input tas_pkg::out_word_t out_word
);
    `TAS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result word changed")
    `TAS_ASSERT_IMP(a_arm_duty, out_valid && out_word.arm_drive == tas_pkg::DRV_COAST, out_word.arm_duty == 8'd0, "arm duty nonzero while coasting")
    `TAS_ASSERT_IMP(a_lid_duty, out_valid && out_word.lid_drive == tas_pkg::DRV_COAST, out_word.lid_duty_res == 8'd0, "lid duty nonzero while coasting")
    `TAS_ASSERT_IMP(a_pan_idle, out_valid, !out_word.busy_bits[0], "pan busy reported")
    `TAS_ASSERT_NEXT(a_accept_out, in_valid && !in_stall && !out_valid, !in_stall || out_valid, "input stalled with no result pending")
endmodule

bind timed_actuator_sequencer tas_checker u_tas_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
